// File: sv/ttq_pkg.sv
package ttq_pkg;

	localparam int ID_W        = 6;
	localparam int DELAY_W     = 48;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 4;

	typedef enum logic [1:0] {
		CMD_SCHED  = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_POLL   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_TASKS = 2'd0,
		CFG_SHIFT = 2'd1,
		CFG_CAP   = 2'd2,
		CFG_NONE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_TAKE_NEXT,
		CELL_TAKE_PREV,
		CELL_LOAD
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_SLACK,
		ST_INSERT,
		ST_REPORT,
		ST_POLL
	} state_t;

	// per-cell compare results, evaluated against the command in flight
	typedef struct packed {
		logic match;   // holds the addressed task
		logic later;   // remaining time greater than delay
		logic due;     // earliest time reached
	} cell_flags_t;

endpackage

// File: sv/ttq_cell.sv
module ttq_cell #(
	parameter int TIME_BITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ttq_pkg::cell_op_t             op,
	input  logic                          prev_v,
	input  logic [ttq_pkg::ID_W-1:0]      prev_id,
	input  logic [TIME_BITS-1:0]          prev_req,
	input  logic [TIME_BITS-1:0]          prev_earl,
	input  logic                          next_v,
	input  logic [ttq_pkg::ID_W-1:0]      next_id,
	input  logic [TIME_BITS-1:0]          next_req,
	input  logic [TIME_BITS-1:0]          next_earl,
	input  logic [ttq_pkg::ID_W-1:0]      load_id,
	input  logic [TIME_BITS-1:0]          load_req,
	input  logic [TIME_BITS-1:0]          load_earl,
	input  logic [TIME_BITS-1:0]          now,
	input  logic [ttq_pkg::DELAY_W-1:0]   delay,
	output logic                          v,
	output logic [ttq_pkg::ID_W-1:0]      id,
	output logic [TIME_BITS-1:0]          req,
	output logic [TIME_BITS-1:0]          earl,
	output ttq_pkg::cell_flags_t          flags
);

	localparam int CW = ((TIME_BITS > ttq_pkg::DELAY_W) ? TIME_BITS : ttq_pkg::DELAY_W) + 1;

	logic                     v_q;
	logic [ttq_pkg::ID_W-1:0] id_q;
	logic [TIME_BITS-1:0]     req_q;
	logic [TIME_BITS-1:0]     earl_q;
	logic [TIME_BITS-1:0]     remain;
	logic [TIME_BITS-1:0]     since;
	logic signed [CW-1:0]     remain_x;
	logic signed [CW-1:0]     delay_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			unique case (op)
				ttq_pkg::CELL_TAKE_NEXT: v_q <= next_v;
				ttq_pkg::CELL_TAKE_PREV: v_q <= prev_v;
				ttq_pkg::CELL_LOAD:      v_q <= 1'b1;
				default:                 v_q <= v_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			ttq_pkg::CELL_TAKE_NEXT: begin
				id_q <= next_id; req_q <= next_req; earl_q <= next_earl;
			end
			ttq_pkg::CELL_TAKE_PREV: begin
				id_q <= prev_id; req_q <= prev_req; earl_q <= prev_earl;
			end
			ttq_pkg::CELL_LOAD: begin
				id_q <= load_id; req_q <= load_req; earl_q <= load_earl;
			end
			default: begin
				id_q <= id_q; req_q <= req_q; earl_q <= earl_q;
			end
		endcase
	end

	always_comb begin
		remain   = req_q - now;
		since    = now - earl_q;
		remain_x = CW'($signed(remain));
		delay_x  = CW'($signed(delay));
		flags.match = v_q && (id_q == load_id);
		flags.later = v_q && (delay_x < remain_x);
		flags.due   = v_q && !since[TIME_BITS-1];
	end

	assign v    = v_q;
	assign id   = id_q;
	assign req  = req_q;
	assign earl = earl_q;

endmodule

// File: sv/timed_task_queue_scheduler.sv
// Schedule/cancel: remove then report, with slack and insert between them for a schedule; one item at a time.
// Poll: one result per cycle per dispatched task, max 16.
// Queue is a row of SLOT_COUNT cells; unlink and insert shift the row by one place.
// NOP command, or bad task id on schedule/cancel: result in the cycle after start.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Reset empties the queue and loads config defaults (16 tasks, shift 0, no cap).
module timed_task_queue_scheduler #(
	parameter int SLOT_COUNT = 16,
	parameter int TIME_BITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [5:0]                    task_id,
	input  logic [47:0]                   delay,
	input  logic [TIME_BITS-1:0]          now,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [47:0]                   cfg_data,
	output logic                          done,
	output logic                          status,
	output logic                          dispatched_valid,
	output logic [5:0]                    dispatched_task,
	output logic                          last,
	output logic                          rearm,
	output logic                          fire_now,
	output logic [TIME_BITS-1:0]          wake_time
);

	localparam int N = SLOT_COUNT;

	ttq_pkg::state_t state_q, state_d;

	logic [4:0]  tasks_q;
	logic [5:0]  shift_q;
	logic [47:0] cap_q;

	ttq_pkg::cmd_t               cmd_q;
	logic [5:0]                  id_q;
	logic [47:0]                 delay_q;
	logic [TIME_BITS-1:0]        now_q;
	logic                        oldv_q;
	logic [5:0]                  oldid_q;
	logic [TIME_BITS-1:0]        rq_q;
	logic [47:0]                 slack_q;
	logic [ttq_pkg::CNT_W-1:0]   k_q;

	logic                        cv   [0:N];
	logic [5:0]                  cid  [0:N];
	logic [TIME_BITS-1:0]        creq [0:N];
	logic [TIME_BITS-1:0]        cearl[0:N];
	ttq_pkg::cell_flags_t        cfl  [0:N];
	ttq_pkg::cell_op_t           cop  [0:N-1];

	logic [N-1:0] match_pre, ins_hit, ins_pre;
	logic [TIME_BITS-1:0] earl_new;
	logic [47:0] slack_raw, slack_new;
	logic [6:0]  limit;
	logic        id_bad;

	logic o_load;
	logic o_status, o_dv, o_last, o_rearm, o_fire;
	logic [5:0] o_task;
	logic [TIME_BITS-1:0] o_wake;
	logic [ttq_pkg::CNT_W-1:0] k_d;

	assign cv[N]    = 1'b0;
	assign cid[N]   = '0;
	assign creq[N]  = '0;
	assign cearl[N] = '0;
	assign cfl[N]   = '0;

	assign earl_new = rq_q - TIME_BITS'($signed(slack_q));

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			if (g == 0) begin : g_first
				ttq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .op(cop[g]),
					.prev_v(1'b0), .prev_id('0), .prev_req('0), .prev_earl('0),
					.next_v(cv[g+1]), .next_id(cid[g+1]),
					.next_req(creq[g+1]), .next_earl(cearl[g+1]),
					.load_id(id_q), .load_req(rq_q), .load_earl(earl_new),
					.now(now_q), .delay(delay_q),
					.v(cv[g]), .id(cid[g]), .req(creq[g]), .earl(cearl[g]),
					.flags(cfl[g])
				);
			end else begin : g_rest
				ttq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .op(cop[g]),
					.prev_v(cv[g-1]), .prev_id(cid[g-1]),
					.prev_req(creq[g-1]), .prev_earl(cearl[g-1]),
					.next_v(cv[g+1]), .next_id(cid[g+1]),
					.next_req(creq[g+1]), .next_earl(cearl[g+1]),
					.load_id(id_q), .load_req(rq_q), .load_earl(earl_new),
					.now(now_q), .delay(delay_q),
					.v(cv[g]), .id(cid[g]), .req(creq[g]), .earl(cearl[g]),
					.flags(cfl[g])
				);
			end
		end
	endgenerate

	// prefix masks: at/after the unlinked cell, and the insert point
	always_comb begin
		for (int i = 0; i < N; i++) begin
			ins_hit[i] = !cv[i] || cfl[i].later;
		end
		match_pre[0] = cfl[0].match;
		ins_pre[0]   = ins_hit[0];
		for (int i = 1; i < N; i++) begin
			match_pre[i] = match_pre[i-1] | cfl[i].match;
			ins_pre[i]   = ins_pre[i-1] | ins_hit[i];
		end
	end

	always_comb begin
		slack_raw = $signed(delay_q) >>> shift_q;
		if (!cap_q[47] && ($signed(slack_raw) > $signed(cap_q))) begin
			slack_new = cap_q;
		end else begin
			slack_new = slack_raw;
		end
	end

	assign limit  = ({2'b00, tasks_q} < 7'(N)) ? {2'b00, tasks_q} : 7'(N);
	assign id_bad = {1'b0, task_id} >= limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		o_load   = 1'b0;
		o_status = 1'b0;
		o_dv     = 1'b0;
		o_task   = '0;
		o_last   = 1'b1;
		o_rearm  = 1'b0;
		o_fire   = 1'b0;
		o_wake   = '0;
		for (int i = 0; i < N; i++) begin
			cop[i] = ttq_pkg::CELL_HOLD;
		end
		unique case (state_q)
			ttq_pkg::ST_IDLE: begin
				if (start) begin
					k_d = '0;
					priority if (ttq_pkg::cmd_t'(cmd) == ttq_pkg::CMD_NOP) begin
						o_load = 1'b1;
					end else if (ttq_pkg::cmd_t'(cmd) == ttq_pkg::CMD_POLL) begin
						state_d = ttq_pkg::ST_POLL;
					end else if (id_bad) begin
						o_load   = 1'b1;
						o_status = 1'b1;
					end else begin
						state_d = ttq_pkg::ST_REMOVE;
					end
				end
			end
			ttq_pkg::ST_REMOVE: begin
				for (int i = 0; i < N; i++) begin
					if (match_pre[i]) cop[i] = ttq_pkg::CELL_TAKE_NEXT;
				end
				state_d = (cmd_q == ttq_pkg::CMD_SCHED) ? ttq_pkg::ST_SLACK
				                                         : ttq_pkg::ST_REPORT;
			end
			ttq_pkg::ST_SLACK: begin
				state_d = ttq_pkg::ST_INSERT;
			end
			ttq_pkg::ST_INSERT: begin
				for (int i = 0; i < N; i++) begin
					if (i > 0 && ins_pre[i] && !ins_hit[i]) begin
						cop[i] = ttq_pkg::CELL_TAKE_PREV;
					end else if (i > 0 && ins_pre[i] && ins_pre[(i > 0) ? i-1 : 0]) begin
						cop[i] = ttq_pkg::CELL_TAKE_PREV;
					end else if (ins_hit[i]) begin
						cop[i] = ttq_pkg::CELL_LOAD;
					end
				end
				state_d = ttq_pkg::ST_REPORT;
			end
			ttq_pkg::ST_REPORT: begin
				o_load  = 1'b1;
				o_rearm = cv[0] && (cid[0] == id_q || (oldv_q && oldid_q == id_q));
				o_fire  = o_rearm && cfl[0].due;
				o_wake  = o_rearm ? creq[0] : '0;
				state_d = ttq_pkg::ST_IDLE;
			end
			ttq_pkg::ST_POLL: begin
				o_load = 1'b1;
				if (cfl[0].due) begin
					for (int i = 0; i < N; i++) begin
						cop[i] = ttq_pkg::CELL_TAKE_NEXT;
					end
					o_dv   = 1'b1;
					o_task = cid[0];
					o_last = (k_q == ttq_pkg::CNT_W'(ttq_pkg::MAX_RESULTS - 1)) || !cfl[1].due;
					if (o_last) begin
						o_rearm = cv[1];
						o_fire  = cfl[1].due;
						o_wake  = cv[1] ? creq[1] : '0;
						state_d = ttq_pkg::ST_IDLE;
					end
					k_d = k_q + 1'b1;
				end else begin
					o_rearm = cv[0];
					o_wake  = cv[0] ? creq[0] : '0;
					state_d = ttq_pkg::ST_IDLE;
				end
			end
			default: state_d = ttq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tasks_q <= 5'd16;
			shift_q <= '0;
			cap_q   <= '1;
			done    <= 1'b0;
			k_q     <= '0;
		end else begin
			done <= o_load;
			k_q  <= k_d;
			if (cfg_valid && cfg_ready) begin
				unique case (ttq_pkg::cfg_idx_t'(cfg_index))
					ttq_pkg::CFG_TASKS: tasks_q <= cfg_data[4:0];
					ttq_pkg::CFG_SHIFT: shift_q <= cfg_data[5:0];
					ttq_pkg::CFG_CAP:   cap_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ttq_pkg::ST_IDLE && start) begin
			cmd_q   <= ttq_pkg::cmd_t'(cmd);
			id_q    <= task_id;
			delay_q <= delay;
			now_q   <= now;
			oldv_q  <= cv[0];
			oldid_q <= cid[0];
		end
		if (state_q == ttq_pkg::ST_SLACK) begin
			rq_q    <= now_q + TIME_BITS'($signed(delay_q));
			slack_q <= slack_new;
		end
		if (o_load) begin
			status           <= o_status;
			dispatched_valid <= o_dv;
			dispatched_task  <= o_task;
			last             <= o_last;
			rearm            <= o_rearm;
			fire_now         <= o_fire;
			wake_time        <= o_wake;
		end
	end

	assign busy      = (state_q != ttq_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

endmodule
